FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the deframer.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Whenever the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLY(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/dhfd_pkg.sv
// Package of the doubled-header frame deframer: header codes, result type and
// the header decode functions. Used by doubled_header_frame_deframer.
`default_nettype none

package dhfd_pkg;

	localparam logic [7:0] HDR_A0 = 8'hA0;
	localparam logic [7:0] HDR_A1 = 8'hA1;
	localparam logic [7:0] HDR_A2 = 8'hA2;
	localparam logic [7:0] HDR_A3 = 8'hA3;
	localparam logic [7:0] HDR_A5 = 8'hA5;
	localparam logic [7:0] HDR_A7 = 8'hA7;
	localparam logic [7:0] HDR_A9 = 8'hA9;
	localparam logic [7:0] HDR_AB = 8'hAB;
	localparam logic [7:0] HDR_AC = 8'hAC;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] frame_code;
		logic [4:0] byte_offset;
		logic [7:0] byte_value;
		logic       frame_end;
	} result_t;

	// Frame length in bytes for a header, zero for an unknown header.
	function automatic logic [4:0] frame_length(input logic [7:0] h);
		logic [4:0] len;
		unique case (h) inside
			HDR_A0, HDR_A1, HDR_A2: len = 5'd7;
			HDR_A3, HDR_A5, HDR_A7, HDR_A9, HDR_AB: len = 5'd4;
			HDR_AC: len = 5'd17;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Number of acknowledge bytes that follow a good frame.
	function automatic logic [2:0] ack_count(input logic [7:0] h);
		logic [2:0] n;
		unique case (h) inside
			HDR_A0, HDR_A2: n = 3'd4;
			HDR_AC: n = 3'd3;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: src/doubled_header_frame_deframer.sv
// Doubled-header frame deframer. Bytes live in a window RAM with a registered read.
// Each request accepts one byte and then scans the window: a header check reads the first two
// bytes (fewer than two end the scan), a matching known header has its frame bytes summed, and a
// good frame emits its payload and acknowledge bytes, which can stall on the output, then finishes.
// Results leave through a one-deep lookahead register and an output register.
// Reset empties the window at once; the RAM itself is not cleared.
`default_nettype none
`include "assert_macros.svh"

module doubled_header_frame_deframer #(
	parameter int BUFFER_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            kind,
	output logic [7:0]      frame_code,
	output logic [4:0]      byte_offset,
	output logic [7:0]      byte_value,
	output logic            frame_end,
	output logic            last
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int XW = (CW > 5) ? CW : 5;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NEXT = 3'd1;
	localparam logic [2:0] ST_HDR0 = 3'd2;
	localparam logic [2:0] ST_HDR1 = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_PAY  = 3'd5;
	localparam logic [2:0] ST_ACK  = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
		logic [AW:0] r;
		r = (s >= (AW+1)'(BUFFER_DEPTH)) ? s - (AW+1)'(BUFFER_DEPTH) : s;
		return r[AW-1:0];
	endfunction

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] start_q;
	logic [CW-1:0] count_q;
	logic [4:0]    k_q, k_d;
	logic [7:0]    h_q, h_d;
	logic [7:0]    sum_q, sum_d;
	logic [7:0]    d_q, d_d;
	logic [4:0]    len_q, len_d;
	logic [2:0]    ack_n_q, ack_n_d;

	logic          pend_v_q, out_v_q, out_last_q;
	dhfd_pkg::result_t pend_q, out_q, gen;

	logic          re, we, fire, gen_v, push_ok, can_out, pend_to_out;
	logic [4:0]    roff;
	logic          drop_en;
	logic [4:0]    drop_n;
	logic [7:0]    rdata;
	logic [7:0]    ack_a;
	logic [4:0]    hdr_len;

	dhfd_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (we),
		.waddr(wrap((AW+1)'(start_q) + (AW+1)'(count_q))),
		.wdata(rx_byte),
		.re   (re),
		.raddr(wrap((AW+1)'(start_q) + (AW+1)'(roff))),
		.rdata(rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign we       = in_valid && in_ready;
	assign can_out  = !out_v_q || out_ready;
	assign push_ok  = !pend_v_q || can_out;
	assign gen_v    = (state_q == ST_PAY) || (state_q == ST_ACK);
	assign fire     = gen_v && push_ok;
	assign pend_to_out = pend_v_q && can_out && (fire || (state_q == ST_FIN));
	assign ack_a    = h_q + 8'd1;
	assign hdr_len  = dhfd_pkg::frame_length(rdata);

	always_comb begin
		gen.frame_code = h_q;
		gen.byte_offset = k_q;
		if (state_q == ST_PAY) begin
			gen.kind       = dhfd_pkg::KIND_PAYLOAD;
			gen.byte_value = rdata;
			gen.frame_end  = (k_q == len_q - 5'd2);
		end else begin
			gen.kind      = dhfd_pkg::KIND_ACK;
			gen.frame_end = (k_q == 5'(ack_n_q) - 5'd1);
			case (k_q[1:0])
				2'd0, 2'd1: gen.byte_value = ack_a;
				2'd2:       gen.byte_value = (ack_n_q == 3'd4) ? d_q : ack_a + ack_a;
				default:    gen.byte_value = ack_a + ack_a + d_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		h_d     = h_q;
		sum_d   = sum_q;
		d_d     = d_q;
		len_d   = len_q;
		ack_n_d = ack_n_q;
		re      = 1'b0;
		roff    = k_q;
		drop_en = 1'b0;
		drop_n  = 5'd1;
		unique case (state_q)
			ST_IDLE: begin
				if (we) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (count_q < CW'(2)) begin
					state_d = ST_FIN;
				end else begin
					re      = 1'b1;
					roff    = 5'd0;
					state_d = ST_HDR0;
				end
			end
			ST_HDR0: begin
				h_d     = rdata;
				re      = 1'b1;
				roff    = 5'd1;
				state_d = ST_HDR1;
			end
			ST_HDR1: begin
				if (rdata != h_q || hdr_len == 5'd0) begin
					drop_en = 1'b1;
					state_d = ST_NEXT;
				end else if (XW'(count_q) < XW'(hdr_len)) begin
					state_d = ST_FIN;
				end else begin
					sum_d   = h_q + h_q;
					len_d   = hdr_len;
					ack_n_d = dhfd_pkg::ack_count(h_q);
					k_d     = 5'd2;
					re      = 1'b1;
					roff    = 5'd2;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (k_q == len_q - 5'd1) begin
					if (rdata == sum_q) begin
						k_d     = 5'd2;
						re      = 1'b1;
						roff    = 5'd2;
						state_d = ST_PAY;
					end else begin
						drop_en = 1'b1;
						state_d = ST_NEXT;
					end
				end else begin
					sum_d = sum_q + rdata;
					if (k_q == 5'd2) begin
						d_d = rdata;
					end
					k_d     = k_q + 5'd1;
					re      = 1'b1;
					roff    = k_q + 5'd1;
				end
			end
			ST_PAY: begin
				if (push_ok) begin
					if (k_q == len_q - 5'd2) begin
						k_d = 5'd0;
						if (ack_n_q != 3'd0) begin
							state_d = ST_ACK;
						end else begin
							drop_en = 1'b1;
							drop_n  = len_q;
							state_d = ST_NEXT;
						end
					end else begin
						k_d  = k_q + 5'd1;
						re   = 1'b1;
						roff = k_q + 5'd1;
					end
				end
			end
			ST_ACK: begin
				if (push_ok) begin
					if (k_q == 5'(ack_n_q) - 5'd1) begin
						drop_en = 1'b1;
						drop_n  = len_q;
						state_d = ST_NEXT;
					end else begin
						k_d = k_q + 5'd1;
					end
				end
			end
			ST_FIN: begin
				if (!pend_v_q || can_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			start_q  <= '0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				count_q <= count_q + CW'(1);
			end else if (drop_en) begin
				start_q <= wrap((AW+1)'(start_q) + (AW+1)'(drop_n));
				count_q <= count_q - CW'(drop_n);
			end
			if (fire) begin
				pend_v_q <= 1'b1;
			end else if (pend_to_out) begin
				pend_v_q <= 1'b0;
			end
			if (pend_to_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		h_q     <= h_d;
		sum_q   <= sum_d;
		d_q     <= d_d;
		len_q   <= len_d;
		ack_n_q <= ack_n_d;
		if (fire) begin
			pend_q <= gen;
		end
		if (pend_to_out) begin
			out_q      <= pend_q;
			out_last_q <= (state_q == ST_FIN);
		end
	end

	assign out_valid   = out_v_q;
	assign kind        = out_q.kind;
	assign frame_code  = out_q.frame_code;
	assign byte_offset = out_q.byte_offset;
	assign byte_value  = out_q.byte_value;
	assign frame_end   = out_q.frame_end;
	assign last        = out_last_q;

	`ASSERT_IMPLY(a_idle_window_small, state_q == ST_IDLE, count_q <= CW'(16),
		"window holds more than sixteen bytes between requests")
	`ASSERT_IMPLY(a_accept_no_pending, in_ready, !pend_v_q,
		"new request accepted with a result still pending")
	`ASSERT_IMPLY(a_move_needs_room, pend_to_out && out_v_q, out_ready,
		"pending result overwrote an untaken output")
	`ASSERT_ALWAYS(a_start_in_range, start_q <= AW'(BUFFER_DEPTH - 1),
		"window start beyond buffer depth")

endmodule

`default_nettype wire

FILE: src/dhfd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module dhfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
